>>> sv/modexp_pkg.sv
// Shared constants for the modular exponentiation block.
package modexp_pkg;

    // Default operand width for base, exponent, modulus and power
    localparam int OPERAND_BITS_DEF = 31;

    // Modulus after reset (1e9 + 7), truncated to the operand width at use
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

endpackage

>>> sv/modexp_mod_step.sv
// One step of MSB-first interleaved modular multiply: (2r + bit*a) mod m.
module modexp_mod_step
    import modexp_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic [OPERAND_BITS-1:0] i_r,    // running remainder, below i_mod
    input  logic [OPERAND_BITS-1:0] i_a,    // addend, at most i_mod
    input  logic                    i_bit,  // current multiplier bit
    input  logic [OPERAND_BITS-1:0] i_mod,
    output logic [OPERAND_BITS-1:0] o_r
);

    localparam int SW = OPERAND_BITS + 2;

    logic [SW-1:0] sum;
    logic [SW-1:0] mod1;
    logic [SW-1:0] mod2;

    // 2r + a stays below 3m, so one of three candidates is the remainder
    always_comb begin
        mod1 = {2'b00, i_mod};
        mod2 = {1'b0, i_mod, 1'b0};
        sum  = {1'b0, i_r, 1'b0} + (i_bit ? {2'b00, i_a} : '0);
        if (sum >= mod2) begin
            o_r = OPERAND_BITS'(sum - mod2);
        end else if (sum >= mod1) begin
            o_r = OPERAND_BITS'(sum - mod1);
        end else begin
            o_r = sum[OPERAND_BITS-1:0];
        end
    end

endmodule

>>> sv/modular_exponentiation.sv
// Modular exponentiation: square-and-multiply over a bit-serial modular multiplier.
// Steps from accept to result valid: reduce the base one bit at a time, skip each leading zero
// exponent bit, then per bit from the leading one down a square plus a multiply when the bit is
// set, then finish. One item at a time; the next is accepted once the block is back in idle.
// Synchronous active-low reset clears control and restores the modulus to 1e9+7.
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Input items
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [OPERAND_BITS-1:0] base, [2*OPERAND_BITS-1:OPERAND_BITS] exponent, zero pad
    input  logic [((2*OPERAND_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Result items
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [OPERAND_BITS-1:0] power, zero pad
    output logic [((OPERAND_BITS+7)/8)*8-1:0]   m_axis_tdata,
    // Modulus write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [OPERAND_BITS-1:0] i_cfg_data
);

    localparam int N  = OPERAND_BITS;
    localparam int CW = $clog2(N);
    localparam logic [N-1:0]  MOD_RST  = MODULUS_RESET[N-1:0];
    localparam logic [CW-1:0] CNT_LAST = CW'(N - 1);
    localparam logic [N-1:0]  ONE      = N'(1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_SQUARE = 6'b001000,
        S_MULT   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state        r_state;
    logic [N-1:0]  r_mod;
    logic [N-1:0]  r_acc;      // running remainder / result
    logic [N-1:0]  r_a;        // addend of the step unit
    logic [N-1:0]  r_mult;     // multiplier bits, MSB first
    logic [N-1:0]  r_base;     // base reduced by the modulus
    logic [N-1:0]  r_exp;      // exponent bits, MSB first
    logic [CW-1:0] r_step;     // multiplier bit count
    logic [CW-1:0] r_ebit;     // exponent bit count
    logic          r_started;  // a set exponent bit has been seen
    logic          r_out_valid;
    logic [N-1:0]  r_out;

    logic [N-1:0]  step_r;
    logic          in_fire;
    logic          last_step;
    logic          last_ebit;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign last_step     = (r_step == '0);
    assign last_ebit     = (r_ebit == '0);

    always_comb begin
        m_axis_tdata        = '0;
        m_axis_tdata[N-1:0] = r_out;
    end

    // Shared bit-serial multiply-reduce step
    modexp_mod_step #(
        .OPERAND_BITS(N)
    ) u_step (
        .i_r  (r_acc),
        .i_a  (r_a),
        .i_bit(r_mult[N-1]),
        .i_mod(r_mod),
        .o_r  (step_r)
    );

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= MOD_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mod <= i_cfg_data;
            end
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_mult    <= s_axis_tdata[N-1:0];
                        r_exp     <= s_axis_tdata[2*N-1:N];
                        r_acc     <= '0;
                        r_a       <= ONE;
                        r_step    <= CNT_LAST;
                        r_ebit    <= CNT_LAST;
                        r_started <= 1'b0;
                        // no reduction possible with a zero modulus: result 0
                        r_state   <= (r_mod == '0) ? S_FINISH : S_REDUCE;
                    end
                end
                // base mod m, one base bit a cycle
                S_REDUCE: begin
                    r_mult <= r_mult << 1;
                    r_step <= r_step - 1'b1;
                    r_acc  <= step_r;
                    if (last_step) begin
                        r_base  <= step_r;
                        r_acc   <= (r_mod == ONE) ? '0 : ONE;
                        r_state <= S_SCAN;
                    end
                end
                // skip leading zeros, else start squaring
                S_SCAN: begin
                    if (!r_started && !r_exp[N-1]) begin
                        r_exp  <= r_exp << 1;
                        r_ebit <= r_ebit - 1'b1;
                        if (last_ebit) begin
                            r_state <= S_FINISH;
                        end
                    end else begin
                        r_started <= 1'b1;
                        r_a       <= r_acc;
                        r_mult    <= r_acc;
                        r_acc     <= '0;
                        r_step    <= CNT_LAST;
                        r_state   <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_mult <= r_mult << 1;
                    r_step <= r_step - 1'b1;
                    r_acc  <= step_r;
                    if (last_step) begin
                        if (r_exp[N-1]) begin
                            r_a     <= step_r;
                            r_mult  <= r_base;
                            r_acc   <= '0;
                            r_step  <= CNT_LAST;
                            r_state <= S_MULT;
                        end else begin
                            r_exp   <= r_exp << 1;
                            r_ebit  <= r_ebit - 1'b1;
                            r_state <= last_ebit ? S_FINISH : S_SCAN;
                        end
                    end
                end
                S_MULT: begin
                    r_mult <= r_mult << 1;
                    r_step <= r_step - 1'b1;
                    r_acc  <= step_r;
                    if (last_step) begin
                        r_exp   <= r_exp << 1;
                        r_ebit  <= r_ebit - 1'b1;
                        r_state <= last_ebit ? S_FINISH : S_SCAN;
                    end
                end
                // hand the result to the output register once it is free
                S_FINISH: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out       <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready)
        else $error("block ready right after accepting an item");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result appeared without finishing an item");

endmodule
